>>> design/service_name_registry_unit_assert.svh
// assertion macros shared by the registry checker
`ifndef SERVICE_NAME_REGISTRY_UNIT_ASSERT_SVH
`define SERVICE_NAME_REGISTRY_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SNR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("registry check failed");

// next-cycle implication, checked out of reset
`define SNR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("registry check failed");

`endif

>>> design/snr_pkg.sv
// shared constants, types and helpers of the service name registry
`default_nettype none

package snr_pkg;

    localparam int ENTRIES    = 16;
    localparam int NAME_BYTES = 16;

    localparam int NAME_SLOTS = 16;
    localparam int NAME_W     = 8 * NAME_SLOTS;
    localparam int HALF_W     = NAME_W / 2;
    localparam int ID_W       = 32;
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic MODE_REGISTER = 1'b0;
    localparam logic MODE_LOOKUP   = 1'b1;

    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [ID_W-1:0]   owner;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic write_entry;
        logic scan_start;
        logic scan_step;
        logic load_result;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_lookup;
        logic scan_more;
        logic rd_vld;
        logic hit;
    } t_dp_status;

    // keeps each byte that lies before the first zero byte and inside NAME_BYTES
    function automatic logic [NAME_W-1:0] name_mask(input logic [NAME_W-1:0] name);
        logic [NAME_W-1:0] m;
        logic              keep;
        m = '0;
        for (int k = 0; k < NAME_SLOTS; k++) begin
            keep = (k < NAME_BYTES);
            for (int j = 0; j <= k; j++) begin
                keep = keep & (|name[8*j +: 8]);
            end
            m[8*k +: 8] = {8{keep}};
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> design/snr_datapath.sv
// registry datapath: request capture, entry table, scan compare and result registers
`default_nettype none

module snr_datapath (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire snr_pkg::t_ctrl_cmd     i_cmd,
    output snr_pkg::t_dp_status         o_status,
    input  wire logic                   i_mode,
    input  wire logic [snr_pkg::ID_W-1:0]   i_sender_id,
    input  wire logic [snr_pkg::HALF_W-1:0] i_name_low,
    input  wire logic [snr_pkg::HALF_W-1:0] i_name_high,
    output logic [snr_pkg::ID_W-1:0]    o_reply_to,
    output logic                        o_reply_kind,
    output logic [snr_pkg::ID_W-1:0]    o_found_id,
    output logic                        o_table_full
);

    logic                          r_mode;
    logic [snr_pkg::ID_W-1:0]      r_sender;
    logic [snr_pkg::NAME_W-1:0]    r_query;
    logic [snr_pkg::NAME_W-1:0]    r_mask;
    logic [snr_pkg::CNT_W-1:0]     r_count;
    logic [snr_pkg::CNT_W-1:0]     r_addr;
    logic                          r_rd_vld;
    snr_pkg::t_entry               r_rd_data;
    logic [snr_pkg::ID_W-1:0]      r_found;
    logic                          r_full;
    logic [snr_pkg::ID_W-1:0]      r_reply_to;
    logic                          r_reply_kind;
    logic [snr_pkg::ID_W-1:0]      r_found_id;
    logic                          r_table_full;

    snr_pkg::t_entry               r_mem [snr_pkg::ENTRIES];

    logic [snr_pkg::NAME_W-1:0]    n_name;
    logic [snr_pkg::NAME_W-1:0]    n_mask;
    logic                          have_room;
    logic                          scan_more;
    logic                          hit;

    assign n_name    = {i_name_high, i_name_low};
    assign n_mask    = snr_pkg::name_mask(n_name);
    assign have_room = (r_count < snr_pkg::CNT_W'(snr_pkg::ENTRIES));
    assign scan_more = (r_addr < r_count);
    assign hit       = (((r_rd_data.name ^ r_query) & r_mask) == '0);

    assign o_status.is_lookup = (r_mode == snr_pkg::MODE_LOOKUP);
    assign o_status.scan_more = scan_more;
    assign o_status.rd_vld    = r_rd_vld;
    assign o_status.hit       = hit;

    // table storage, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_entry && have_room) begin
            r_mem[r_count[snr_pkg::IDX_W-1:0]] <= '{name: r_query, owner: r_sender};
        end
        if (i_cmd.scan_step && scan_more) begin
            r_rd_data <= r_mem[r_addr[snr_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.write_entry && have_room) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_addr   <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_vld <= scan_more;
                if (scan_more) begin
                    r_addr <= r_addr + 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode   <= i_mode;
            r_sender <= i_sender_id;
            r_query  <= n_name & n_mask;
            r_mask   <= n_mask;
        end
        if (i_cmd.write_entry) begin
            r_found <= '0;
            r_full  <= !have_room;
        end
        if (i_cmd.scan_start) begin
            r_found <= '0;
            r_full  <= 1'b0;
        end else if (i_cmd.scan_step && r_rd_vld && hit) begin
            r_found <= r_rd_data.owner;
        end
        if (i_cmd.load_result) begin
            r_reply_to   <= r_sender;
            r_reply_kind <= r_mode;
            r_found_id   <= r_found;
            r_table_full <= r_full;
        end
    end

    assign o_reply_to   = r_reply_to;
    assign o_reply_kind = r_reply_kind;
    assign o_found_id   = r_found_id;
    assign o_table_full = r_table_full;

endmodule

`default_nettype wire

>>> design/snr_ctrl.sv
// registry controller: sequences capture, insert, scan and result handoff
`default_nettype none

module snr_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    output logic                    o_valid,
    input  wire logic               i_stall,
    input  wire snr_pkg::t_dp_status i_status,
    output snr_pkg::t_ctrl_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;
    logic   scan_end;

    assign accept   = i_valid && !r_busy;
    assign out_free = !r_out_valid || !i_stall;
    // stop on the first hit, or once every valid entry has been compared
    assign scan_end = (i_status.rd_vld && i_status.hit) ||
                      (!i_status.rd_vld && !i_status.scan_more);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_START;
                end
            end
            S_START: begin
                if (i_status.is_lookup) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    o_cmd.write_entry = 1'b1;
                    n_state           = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (o_cmd.load_result) begin
                r_busy <= 1'b0;
            end
            if (o_cmd.load_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall = r_busy;
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

>>> design/service_name_registry_unit.sv
// Service name registry: 16-entry name-to-id table with prefix lookup.
// One request is handled at a time. A register request writes its entry and
// then has its reply offered. A lookup scans the stored entries in order and
// stops at the first match, or once all stored entries have been compared
// without one. The scan reads the entry table one entry per cycle and
// compares the registered read against the masked query. A new request can be
// accepted once the previous reply has been moved to the output register, even
// if the downstream side has not taken it yet. A stall on the previous reply
// can hold the next reply back from the output register. A register request
// on a full table is dropped and answered with o_table_full set.
`default_nettype none

module service_name_registry_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic                       i_mode,
    input  wire logic [snr_pkg::ID_W-1:0]   i_sender_id,
    input  wire logic [snr_pkg::HALF_W-1:0] i_name_low,
    input  wire logic [snr_pkg::HALF_W-1:0] i_name_high,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [snr_pkg::ID_W-1:0]        o_reply_to,
    output logic                            o_reply_kind,
    output logic [snr_pkg::ID_W-1:0]        o_found_id,
    output logic                            o_table_full
);

    snr_pkg::t_ctrl_cmd  cmd;
    snr_pkg::t_dp_status status;

    snr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    snr_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_mode       (i_mode),
        .i_sender_id  (i_sender_id),
        .i_name_low   (i_name_low),
        .i_name_high  (i_name_high),
        .o_reply_to   (o_reply_to),
        .o_reply_kind (o_reply_kind),
        .o_found_id   (o_found_id),
        .o_table_full (o_table_full)
    );

endmodule

`default_nettype wire

>>> design/snr_checker.sv
// port-level checks of the service name registry, bound to the top level
`default_nettype none

`include "service_name_registry_unit_assert.svh"

module snr_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic                       o_stall,
    input  wire logic                       o_valid,
    input  wire logic                       i_stall,
    input  wire logic [snr_pkg::ID_W-1:0]   o_reply_to,
    input  wire logic                       o_reply_kind,
    input  wire logic [snr_pkg::ID_W-1:0]   o_found_id,
    input  wire logic                       o_table_full
);

    // an accepted request blocks the input until its reply is formed
    `SNR_ASSERT_NEXT(a_busy_after_request, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // a reply offered while stalled stays offered
    `SNR_ASSERT_NEXT(a_reply_held, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_reply_to))

    // register acknowledgements never carry an id
    `SNR_ASSERT_NOW(a_ack_no_id, i_clk, i_rst_n, o_valid && (o_reply_kind == snr_pkg::MODE_REGISTER), o_found_id == '0)

    // lookup answers never report a full table
    `SNR_ASSERT_NOW(a_lookup_not_full, i_clk, i_rst_n, o_valid && (o_reply_kind == snr_pkg::MODE_LOOKUP), !o_table_full)

endmodule

bind service_name_registry_unit snr_checker u_snr_checker (.*);

`default_nettype wire
